// ===== src/mws_pkg.sv =====
`timescale 1ns / 1ps

package mws_pkg;

	localparam int ID_W            = 31;
	localparam int MAX_WINDOWS_DEF = 16;

	typedef enum logic [1:0] {
		OP_OPEN   = 2'd0,
		OP_SWITCH = 2'd1,
		OP_CLOSE  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_TOP   = 2'd1,
		KIND_BLANK = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT_DN,
		ST_SHIFT_UP,
		ST_PUT_TOP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]      operation;
		logic [ID_W-1:0] window_id;
	} req_item_t;

	typedef struct packed {
		logic [1:0]      report_kind;
		logic [ID_W-1:0] top_id;
		logic            all_closed;
		logic            full_refused;
	} rsp_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic dn_from_count;
		logic dn_from_pos;
		logic shift_dn;
		logic up_start;
		logic shift_up;
		logic put_top;
		logic cnt_inc;
		logic cnt_dec;
		logic cnt_clear;
		logic res_top;
		logic res_blank;
		logic res_refused;
		logic emit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic scan_done;
		logic found;
		logic pos_zero;
		logic cnt_zero;
		logic cnt_one;
		logic cnt_full;
		logic dn_done;
		logic up_done;
		logic out_free;
	} sts_t;

endpackage

// ===== src/mws_datapath.sv =====
`timescale 1ns / 1ps

module mws_datapath #(
	parameter int MAX_WINDOWS = mws_pkg::MAX_WINDOWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mws_pkg::req_item_t req_item,
	input  mws_pkg::ctl_t     ctl,
	output mws_pkg::sts_t     sts,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output mws_pkg::rsp_item_t rsp_item
);

	localparam int IDX_W = $clog2(MAX_WINDOWS);
	localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOWS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	logic [mws_pkg::ID_W-1:0] mem_q [MAX_WINDOWS];
	logic [mws_pkg::ID_W-1:0] rd_q;

	mws_pkg::op_t             op_q;
	logic [mws_pkg::ID_W-1:0] id_q;
	logic [mws_pkg::ID_W-1:0] top_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         ptr_q;
	logic [CNT_W-1:0]         pos_q;
	logic [CNT_W-1:0]         ra_q;
	logic                     rv_q;
	logic                     found_q;
	mws_pkg::kind_t           kind_q;
	logic                     closed_q;
	logic                     refused_q;
	logic                     rsp_valid_q;
	mws_pkg::rsp_item_t       rsp_item_q;

	logic                     re;
	logic [CNT_W-1:0]         raddr;
	logic                     we;
	logic [CNT_W-1:0]         waddr;
	logic [mws_pkg::ID_W-1:0] wdata;
	logic                     hit;
	logic                     restart;

	always_comb begin
		re    = 1'b0;
		raddr = ptr_q;
		if (ctl.scan && (ptr_q < count_q)) begin
			re = 1'b1;
		end
		if (ctl.shift_dn && (ptr_q != '0)) begin
			re    = 1'b1;
			raddr = CNT_W'(ptr_q - 1'b1);
		end
		if (ctl.shift_up && (ptr_q < count_q)) begin
			re = 1'b1;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rd_q;
		if (ctl.shift_dn && rv_q) begin
			we    = 1'b1;
			waddr = CNT_W'(ra_q + 1'b1);
		end
		if (ctl.shift_up && rv_q) begin
			we    = 1'b1;
			waddr = CNT_W'(ra_q - 1'b1);
		end
		if (ctl.put_top) begin
			we    = 1'b1;
			waddr = '0;
			wdata = id_q;
		end
	end

	assign hit     = ctl.scan && rv_q && !found_q && (rd_q == id_q);
	assign restart = ctl.load || ctl.dn_from_count || ctl.dn_from_pos || ctl.up_start;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr[IDX_W-1:0]] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rv_q        <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rv_q <= re && !restart;
			if (ctl.load) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
			if (ctl.cnt_clear) begin
				count_q <= '0;
			end else if (ctl.cnt_inc) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (ctl.cnt_dec) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
			if (ctl.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q      <= mws_pkg::op_t'(req_item.operation);
			id_q      <= req_item.window_id;
			kind_q    <= mws_pkg::KIND_NONE;
			closed_q  <= 1'b0;
			refused_q <= 1'b0;
		end else begin
			if (ctl.res_top) begin
				kind_q <= mws_pkg::KIND_TOP;
			end
			if (ctl.res_blank) begin
				kind_q   <= mws_pkg::KIND_BLANK;
				closed_q <= 1'b1;
			end
			if (ctl.res_refused) begin
				refused_q <= 1'b1;
			end
		end
		if (re) begin
			ra_q <= raddr;
		end
		if (hit) begin
			pos_q <= ra_q;
		end
		// entry 0 is mirrored so the result needs no extra read
		if (we && (waddr == '0)) begin
			top_q <= wdata;
		end
		priority if (ctl.load) begin
			ptr_q <= '0;
		end else if (ctl.dn_from_count) begin
			ptr_q <= count_q;
		end else if (ctl.dn_from_pos) begin
			ptr_q <= pos_q;
		end else if (ctl.up_start) begin
			ptr_q <= CNT_W'(pos_q + 1'b1);
		end else if (re && ctl.shift_dn) begin
			ptr_q <= CNT_W'(ptr_q - 1'b1);
		end else if (re) begin
			ptr_q <= CNT_W'(ptr_q + 1'b1);
		end else begin
			ptr_q <= ptr_q;
		end
		if (ctl.emit) begin
			rsp_item_q.report_kind  <= kind_q;
			rsp_item_q.top_id       <= (kind_q == mws_pkg::KIND_TOP) ? top_q : '0;
			rsp_item_q.all_closed   <= closed_q;
			rsp_item_q.full_refused <= refused_q;
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.scan_done = found_q || ((ptr_q >= count_q) && !rv_q);
		sts.found     = found_q;
		sts.pos_zero  = (pos_q == '0);
		sts.cnt_zero  = (count_q == '0);
		sts.cnt_one   = (count_q == CNT_ONE);
		sts.cnt_full  = (count_q == CNT_MAX);
		sts.dn_done   = (ptr_q == '0) && !rv_q;
		sts.up_done   = (ptr_q >= count_q) && !rv_q;
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

endmodule

// ===== src/mws_ctrl.sv =====
`timescale 1ns / 1ps

module mws_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mws_pkg::sts_t sts,
	output mws_pkg::ctl_t ctl
);

	mws_pkg::state_t state_q;
	mws_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mws_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_stall = (state_q != mws_pkg::ST_IDLE);
		unique case (state_q)
			mws_pkg::ST_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = mws_pkg::ST_SCAN;
				end
			end
			mws_pkg::ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = mws_pkg::ST_FINISH;
					unique case (sts.op)
						mws_pkg::OP_OPEN: begin
							ctl.res_top = 1'b1;
							if (!sts.found && sts.cnt_full) begin
								ctl.res_refused = 1'b1;
							end else if (!sts.found) begin
								ctl.dn_from_count = 1'b1;
								state_d           = mws_pkg::ST_SHIFT_DN;
							end
						end
						mws_pkg::OP_SWITCH: begin
							if (sts.found) begin
								ctl.res_top = 1'b1;
								if (!sts.pos_zero) begin
									ctl.dn_from_pos = 1'b1;
									state_d         = mws_pkg::ST_SHIFT_DN;
								end
							end
						end
						mws_pkg::OP_CLOSE: begin
							// last window goes whatever id was named
							if (sts.cnt_one) begin
								ctl.cnt_clear = 1'b1;
								ctl.res_blank = 1'b1;
							end else if (!sts.cnt_zero) begin
								ctl.res_top = 1'b1;
								if (sts.found) begin
									ctl.up_start = 1'b1;
									state_d      = mws_pkg::ST_SHIFT_UP;
								end
							end
						end
						mws_pkg::OP_NONE: begin
						end
						default: begin
						end
					endcase
				end
			end
			mws_pkg::ST_SHIFT_DN: begin
				ctl.shift_dn = 1'b1;
				if (sts.dn_done) begin
					state_d = mws_pkg::ST_PUT_TOP;
				end
			end
			mws_pkg::ST_PUT_TOP: begin
				ctl.put_top = 1'b1;
				ctl.cnt_inc = (sts.op == mws_pkg::OP_OPEN);
				state_d     = mws_pkg::ST_FINISH;
			end
			mws_pkg::ST_SHIFT_UP: begin
				ctl.shift_up = 1'b1;
				if (sts.up_done) begin
					ctl.cnt_dec = 1'b1;
					state_d     = mws_pkg::ST_FINISH;
				end
			end
			mws_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = mws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mws_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/mru_window_stack.sv =====
`timescale 1ns / 1ps
// one item in flight; a linear search of the stack memory and a one-entry-per-cycle
// shift through its single write port do the work of each item
// the result register lets the next item be taken while a result waits
// reset clears the count, the state machine and the result valid; stack memory is not cleared

module mru_window_stack #(
	parameter int MAX_WINDOWS = mws_pkg::MAX_WINDOWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  mws_pkg::req_item_t req_item,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output mws_pkg::rsp_item_t rsp_item
);

	mws_pkg::ctl_t ctl;
	mws_pkg::sts_t sts;

	mws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	mws_datapath #(
		.MAX_WINDOWS (MAX_WINDOWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second transfer taken while an item is in flight");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> sts.out_free)
		else $error("result register overwritten before transfer");

	a_one_mem_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.scan, ctl.shift_dn, ctl.shift_up, ctl.put_top}))
		else $error("more than one stack memory operation at once");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((!rsp_item.full_refused || rsp_item.report_kind == mws_pkg::KIND_TOP) &&
		(!rsp_item.all_closed || rsp_item.report_kind == mws_pkg::KIND_BLANK)))
		else $error("result flags disagree with report kind");

endmodule

// ===== bench/mws_checker.sv =====
`timescale 1ns / 1ps

module mws_checker #(
	parameter int MAX_WINDOWS = mws_pkg::MAX_WINDOWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  mws_pkg::req_item_t req_item,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  mws_pkg::rsp_item_t rsp_item,
	output int                 fail_count,
	output int                 pending
);

	logic [mws_pkg::ID_W-1:0] held_ids [MAX_WINDOWS];
	int                       held_count;
	mws_pkg::rsp_item_t       expected_reports [$];
	int                       mismatches;
	logic                     rsp_was_stalled;
	mws_pkg::rsp_item_t       stalled_item;

	// pos == held_count brings a new id in from below the bottom
	function automatic void move_to_top(int pos, logic [mws_pkg::ID_W-1:0] id);
		for (int i = pos; i > 0; i--)
			held_ids[i] = held_ids[i-1];
		held_ids[0] = id;
	endfunction

	function automatic mws_pkg::rsp_item_t apply_command(mws_pkg::req_item_t cmd);
		mws_pkg::rsp_item_t       res;
		logic [mws_pkg::ID_W-1:0] id;
		int                       pos;
		res = '0;
		id  = cmd.window_id;
		pos = held_count;
		for (int i = held_count - 1; i >= 0; i--)
			if (held_ids[i] == id)
				pos = i;
		case (mws_pkg::op_t'(cmd.operation))
			mws_pkg::OP_OPEN: begin
				if (pos == held_count) begin
					if (held_count < MAX_WINDOWS) begin
						move_to_top(held_count, id);
						held_count++;
					end else begin
						res.full_refused = 1'b1;
					end
				end
				res.report_kind = mws_pkg::KIND_TOP;
			end
			mws_pkg::OP_SWITCH: begin
				if (pos < held_count) begin
					move_to_top(pos, id);
					res.report_kind = mws_pkg::KIND_TOP;
				end
			end
			mws_pkg::OP_CLOSE: begin
				// the last window goes whatever id was named
				if (held_count == 1) begin
					held_count      = 0;
					res.report_kind = mws_pkg::KIND_BLANK;
					res.all_closed  = 1'b1;
				end else if (held_count > 1) begin
					if (pos < held_count) begin
						for (int i = pos; i < held_count - 1; i++)
							held_ids[i] = held_ids[i+1];
						held_count--;
					end
					res.report_kind = mws_pkg::KIND_TOP;
				end
			end
			default: ;
		endcase
		if (res.report_kind == mws_pkg::KIND_TOP)
			res.top_id = held_ids[0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mws_pkg::rsp_item_t want;
		if (!arst_n) begin
			expected_reports.delete();
			held_count      = 0;
			mismatches      = 0;
			rsp_was_stalled = 1'b0;
			fail_count     <= 0;
			pending        <= 0;
		end else begin
			if (req_valid && !req_stall)
				expected_reports.push_back(apply_command(req_item));
			// a stalled result must stay put until its transfer
			if (rsp_was_stalled && (!rsp_valid || rsp_item !== stalled_item)) begin
				$error("rsp_item: changed or withdrawn while stalled");
				mismatches++;
			end
			rsp_was_stalled = rsp_valid && rsp_stall;
			stalled_item    = rsp_item;
			if (rsp_valid && !rsp_stall) begin
				if (expected_reports.size() == 0) begin
					$error("rsp_item: result with no command waiting");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					if (rsp_item.report_kind !== want.report_kind) begin
						$error("report_kind: expected %0d, got %0d",
							want.report_kind, rsp_item.report_kind);
						mismatches++;
					end
					if (rsp_item.top_id !== want.top_id) begin
						$error("top_id: expected %0h, got %0h", want.top_id, rsp_item.top_id);
						mismatches++;
					end
					if (rsp_item.all_closed !== want.all_closed) begin
						$error("all_closed: expected %0b, got %0b",
							want.all_closed, rsp_item.all_closed);
						mismatches++;
					end
					if (rsp_item.full_refused !== want.full_refused) begin
						$error("full_refused: expected %0b, got %0b",
							want.full_refused, rsp_item.full_refused);
						mismatches++;
					end
				end
			end
			pending    <= expected_reports.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int                       CLOCK_LIMIT   = 1_000_000;
	localparam int                       HOLD_LEN      = 400;
	localparam int                       POOL_SIZE     = 22;
	localparam int                       PHASE_ITEMS   = 310;
	localparam int                       SETTLE_CYCLES = 2 * mws_pkg::MAX_WINDOWS_DEF + 16;
	localparam logic [mws_pkg::ID_W-1:0] ID_MAX        = '1;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	mws_pkg::req_item_t req_item  = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	mws_pkg::rsp_item_t rsp_item;

	int   fail_count;
	int   pending;
	int   cycle_count    = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   hold_left      = 0;
	logic hold_toggle    = 1'b0;
	logic hold_seen      = 1'b0;

	logic [mws_pkg::ID_W-1:0] id_pool [POOL_SIZE];

	mru_window_stack i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	mws_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_item   (req_item),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_item   (rsp_item),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// receiver side; a toggle of hold_toggle starts a long hold-off
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_LEN;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_item(input mws_pkg::op_t op, input logic [mws_pkg::ID_W-1:0] id);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= '{operation: op, window_id: id};
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending != 0);
	endtask

	// grow mode leans to open so the stack fills, shrink mode leans to close so it drains
	function automatic void pick_command(input bit grow, output mws_pkg::op_t op,
			output logic [mws_pkg::ID_W-1:0] id);
		int roll;
		roll = $urandom_range(99);
		if (roll < 4)
			op = mws_pkg::OP_NONE;
		else if (grow)
			op = (roll < 64) ? mws_pkg::OP_OPEN :
				(roll < 82) ? mws_pkg::OP_SWITCH : mws_pkg::OP_CLOSE;
		else
			op = (roll < 28) ? mws_pkg::OP_OPEN :
				(roll < 52) ? mws_pkg::OP_SWITCH : mws_pkg::OP_CLOSE;
		// mostly ids from a small pool so that switch and close find their window
		if ($urandom_range(99) < 90)
			id = id_pool[$urandom_range(POOL_SIZE - 1)];
		else
			id = mws_pkg::ID_W'($urandom);
	endfunction

	initial begin
		wait (cycle_count >= CLOCK_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int                       idle_pcts [4];
		int                       stall_pcts [4];
		bit                       grow_mode;
		int                       mode_left;
		mws_pkg::op_t             op;
		logic [mws_pkg::ID_W-1:0] id;

		idle_pcts  = '{0, 87, 0, 7};
		stall_pcts = '{0, 0, 87, 7};
		grow_mode  = 1'b1;
		mode_left  = 0;
		id_pool[0] = '0;
		id_pool[1] = ID_MAX;
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = mws_pkg::ID_W'($urandom);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(mws_pkg::OP_CLOSE, '0);
		send_item(mws_pkg::OP_SWITCH, ID_MAX);
		send_item(mws_pkg::OP_NONE, ID_MAX);
		send_item(mws_pkg::OP_OPEN, ID_MAX);
		send_item(mws_pkg::OP_CLOSE, 31'd5);
		send_item(mws_pkg::OP_OPEN, '0);
		send_item(mws_pkg::OP_OPEN, '0);
		send_item(mws_pkg::OP_SWITCH, '0);
		for (int i = 0; i < mws_pkg::MAX_WINDOWS_DEF - 1; i++)
			send_item(mws_pkg::OP_OPEN, mws_pkg::ID_W'(1) << i);
		send_item(mws_pkg::OP_OPEN, ID_MAX);
		send_item(mws_pkg::OP_SWITCH, 31'h2aaa_aaaa);
		send_item(mws_pkg::OP_SWITCH, '0);
		send_item(mws_pkg::OP_CLOSE, 31'h5555_5555);
		send_item(mws_pkg::OP_CLOSE, mws_pkg::ID_W'(1) << 7);
		req_valid <= 1'b0;
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = idle_pcts[phase];
			recv_stall_pct = stall_pcts[phase];
			// long hold-off while items keep coming, so the input backs up
			if (phase == 0)
				hold_toggle <= ~hold_toggle;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (mode_left == 0) begin
					grow_mode = ~grow_mode;
					mode_left = $urandom_range(50, 15);
				end
				mode_left--;
				pick_command(grow_mode, op, id);
				send_item(op, id);
			end
			req_valid <= 1'b0;
			wait_drained();
		end

		recv_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
